/* hw/rtl/trqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trqd_pkg
// Shared types and codes of the run queue dispatcher: commands, response
// codes, thread states, slot kinds, sequencer steps and the status bundle.
// ----------------------------------------------------------------------------
package trqd_pkg;

   localparam int CMD_W    = 2;
   localparam int TID_W    = 6;
   localparam int ENG_W    = 3;
   localparam int RSP_W    = 2;
   localparam int CSR_W    = 4;
   localparam int TAG_W    = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE    = 2'd0,
      CMD_RESCHEDULE = 2'd1,
      CMD_SWITCH     = 2'd2,
      CMD_DEQUEUE    = 2'd3
   } cmd_type;

   localparam logic [RSP_W-1:0] RSP_OK        = 2'd0;
   localparam logic [RSP_W-1:0] RSP_BAD_STATE = 2'd1;
   localparam logic [RSP_W-1:0] RSP_NO_QUEUE  = 2'd2;

   localparam logic [1:0] THR_READY   = 2'd0;
   localparam logic [1:0] THR_QUEUED  = 2'd1;
   localparam logic [1:0] THR_RUNNING = 2'd2;

   typedef enum logic [1:0] {
      SLOT_NONE,
      SLOT_IDLE,
      SLOT_THREAD
   } slot_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_ENQ_CHECK,
      ST_RES_REFILL,
      ST_POP_HEAD,
      ST_POP_ENTRY,
      ST_POP_CHECK,
      ST_SW_CUR,
      ST_SW_PUSH,
      ST_SW_INSTALL,
      ST_DEQ_CHECK,
      ST_DONE
   } step_type;

   typedef struct packed {
      cmd_type cmd;
      logic    engine_ok;
      logic    pend_none;
      logic    cur_thread;
      logic    fifo_empty;
      logic    entry_live;
      logic    local_mode;
      logic    rec_running;
      logic    out_free;
   } dp_status_type;

endpackage

/* hw/rtl/trqd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trqd_ctrl
// Sequencer of the dispatcher: steps one command through the datapath and
// holds off new transactions until the response is registered.
// ----------------------------------------------------------------------------
module trqd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  trqd_pkg::dp_status_type dp_status,
   output trqd_pkg::step_type     step
);
   import trqd_pkg::*;

   step_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      step      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            priority if (dp_status.cmd == CMD_ENQUEUE) state_in = ST_ENQ_CHECK;
            else if (!dp_status.engine_ok) state_in = ST_DONE;
            else if (dp_status.cmd == CMD_RESCHEDULE) state_in = ST_RES_REFILL;
            else if (dp_status.cmd == CMD_SWITCH) begin
               priority if (dp_status.pend_none) state_in = ST_DONE;
               else if (dp_status.cur_thread) state_in = ST_SW_CUR;
               else state_in = ST_SW_INSTALL;
            end else state_in = ST_DEQ_CHECK;
         end
         ST_ENQ_CHECK:  state_in = ST_DONE;
         ST_RES_REFILL: state_in = ST_POP_HEAD;
         ST_POP_HEAD: begin
            priority if (!dp_status.fifo_empty) state_in = ST_POP_ENTRY;
            else if (dp_status.local_mode) state_in = ST_POP_HEAD;
            else state_in = ST_DONE;
         end
         ST_POP_ENTRY: state_in = ST_POP_CHECK;
         ST_POP_CHECK: begin
            state_in = dp_status.entry_live ? ST_DONE : ST_POP_HEAD;
         end
         ST_SW_CUR: begin
            state_in = dp_status.rec_running ? ST_SW_PUSH : ST_SW_INSTALL;
         end
         ST_SW_PUSH:    state_in = ST_SW_INSTALL;
         ST_SW_INSTALL: state_in = ST_DONE;
         ST_DEQ_CHECK:  state_in = ST_DONE;
         ST_DONE: begin
            if (dp_status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hw/rtl/trqd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trqd_datapath
// Thread table, FIFO storage and pointers, per-engine tickets and slots,
// and the response register, updated one sequencer step at a time.
// ----------------------------------------------------------------------------
module trqd_datapath #(
   parameter int MAX_THREADS       = 64,
   parameter int NUM_ENGINES       = 8,
   parameter int ENGINES_PER_GROUP = 4,
   parameter int QUEUE_DEPTH       = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  trqd_pkg::step_type            step,
   output trqd_pkg::dp_status_type       dp_status,
   input  logic [trqd_pkg::CMD_W-1:0]    req_cmd,
   input  logic [trqd_pkg::TID_W-1:0]    req_thread_id,
   input  logic                          req_has_affinity,
   input  logic [trqd_pkg::ENG_W-1:0]    req_engine_id,
   input  logic                          csr_valid,
   input  logic [trqd_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [trqd_pkg::RSP_W-1:0]    rsp_status,
   output logic [trqd_pkg::TID_W-1:0]    rsp_chosen_thread,
   output logic                          rsp_chose_idle,
   output logic                          rsp_reschedule_needed,
   output logic                          rsp_notify_valid,
   output logic [trqd_pkg::ENG_W-1:0]    rsp_notify_engine
);
   import trqd_pkg::*;

   localparam int NUM_GROUPS = (NUM_ENGINES + ENGINES_PER_GROUP - 1) / ENGINES_PER_GROUP;
   localparam int NQ    = NUM_ENGINES + NUM_GROUPS;
   localparam int TW    = $clog2(MAX_THREADS);
   localparam int EW    = (NUM_ENGINES > 1) ? $clog2(NUM_ENGINES) : 1;
   localparam int QW    = $clog2(NQ);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int PTRW  = $clog2(QUEUE_DEPTH);
   localparam int SAW   = $clog2(NQ * QUEUE_DEPTH);
   localparam int ECW   = $clog2(NUM_ENGINES + 1);
   localparam int GEW   = $clog2(ENGINES_PER_GROUP + 1);
   localparam int LTW   = CW + GEW;
   localparam int ENTW  = TAG_W + TW;
   localparam int EXW   = (EW > ENG_W) ? EW : ENG_W;
   localparam int TXW   = (TW > TID_W) ? TW : TID_W;

   function automatic logic [GEW-1:0] grp_engines(input int g, input logic [ECW-1:0] n);
      int left;
      left = int'(n) - g * ENGINES_PER_GROUP;
      if (left <= 0) return '0;
      if (left > ENGINES_PER_GROUP) return GEW'(ENGINES_PER_GROUP);
      return GEW'(left);
   endfunction

   // latched transaction and configuration
   logic [ECW-1:0]   eiu_ff;
   cmd_type          cmd_ff, cmd_in;
   logic [TID_W-1:0] tid_ff, tid_in;
   logic             aff_ff, aff_in;
   logic [ENG_W-1:0] eng_ff, eng_in;

   // working registers
   logic [QW-1:0]    q_ff, q_in;
   logic             qnone_ff, qnone_in;
   logic             lmode_ff, lmode_in;

   logic [PTRW-1:0]  head_ff [NQ];
   logic [PTRW-1:0]  head_in [NQ];
   logic [PTRW-1:0]  tail_ff [NQ];
   logic [PTRW-1:0]  tail_in [NQ];
   logic [CW-1:0]    fill_ff [NQ];
   logic [CW-1:0]    fill_in [NQ];
   logic [CW-1:0]    cnt_ff  [NQ];
   logic [CW-1:0]    cnt_in  [NQ];

   logic [LTW-1:0]   lt_ff  [NUM_ENGINES];
   logic [LTW-1:0]   lt_in  [NUM_ENGINES];
   logic [CW-1:0]    sht_ff [NUM_ENGINES];
   logic [CW-1:0]    sht_in [NUM_ENGINES];
   slot_kind_type    pk_ff  [NUM_ENGINES];
   slot_kind_type    pk_in  [NUM_ENGINES];
   logic [TW-1:0]    pt_ff  [NUM_ENGINES];
   logic [TW-1:0]    pt_in  [NUM_ENGINES];
   slot_kind_type    ck_ff  [NUM_ENGINES];
   slot_kind_type    ck_in  [NUM_ENGINES];
   logic [TW-1:0]    ct_ff  [NUM_ENGINES];
   logic [TW-1:0]    ct_in  [NUM_ENGINES];

   // result being built and response register
   logic [RSP_W-1:0] res_status_ff, res_status_in;
   logic [TID_W-1:0] res_chosen_ff, res_chosen_in;
   logic             res_idle_ff, res_idle_in;
   logic             res_resched_ff, res_resched_in;
   logic             res_nvalid_ff, res_nvalid_in;
   logic [ENG_W-1:0] res_neng_ff, res_neng_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_status_ff;
   logic [TID_W-1:0] rsp_chosen_ff;
   logic             rsp_idle_ff;
   logic             rsp_resched_ff;
   logic             rsp_nvalid_ff;
   logic [ENG_W-1:0] rsp_neng_ff;

   // thread table
   logic [1:0]       st_mem  [MAX_THREADS];
   logic [QW-1:0]    pl_mem  [MAX_THREADS];
   logic [ECW-1:0]   pin_mem [MAX_THREADS];
   logic [TAG_W-1:0] tag_mem [MAX_THREADS];
   logic             tvld_ff [MAX_THREADS];

   logic             trd_en;
   logic [TW-1:0]    trd_addr;
   logic [TW-1:0]    trd_addr_ff;
   logic             rvld_ff;
   logic [1:0]       rst_raw_ff;
   logic [QW-1:0]    rpl_raw_ff;
   logic [ECW-1:0]   rpin_raw_ff;
   logic [TAG_W-1:0] rtag_raw_ff;
   logic [1:0]       rst;
   logic [QW-1:0]    rpl;
   logic [ECW-1:0]   rpin;
   logic [TAG_W-1:0] rtag;

   logic             twr_en;
   logic [1:0]       twr_st;
   logic [QW-1:0]    twr_pl;
   logic [ECW-1:0]   twr_pin;
   logic [TAG_W-1:0] twr_tag;

   // fifo storage
   logic [ENTW-1:0]  sto_mem [NQ * QUEUE_DEPTH];
   logic             srd_en;
   logic [SAW-1:0]   srd_addr;
   logic [ENTW-1:0]  ent_ff;
   logic             sw_en;
   logic [SAW-1:0]   sw_addr;
   logic [ENTW-1:0]  sw_data;

   // decoded fields
   logic [EXW-1:0]   e_x;
   logic [EW-1:0]    e_idx;
   logic [QW-1:0]    e_q;
   logic [TXW-1:0]   tid_x;
   logic [TW-1:0]    tid_idx;
   logic             tid_ok;
   logic             engine_ok;
   int               grp_sel;
   logic [QW-1:0]    sq;
   logic             q_full;
   logic             entry_live;
   logic             out_free;

   assign e_x     = EXW'(eng_ff);
   assign e_idx   = e_x[EW-1:0];
   assign e_q     = QW'(e_idx);
   assign tid_x   = TXW'(tid_ff);
   assign tid_idx = tid_x[TW-1:0];
   assign tid_ok  = (32'(tid_ff) < MAX_THREADS);
   assign engine_ok = (32'(eng_ff) < 32'(eiu_ff));
   assign q_full  = (32'(fill_ff[q_ff]) >= QUEUE_DEPTH);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rst  = rvld_ff ? rst_raw_ff  : THR_READY;
   assign rpl  = rvld_ff ? rpl_raw_ff  : '0;
   assign rpin = rvld_ff ? rpin_raw_ff : '0;
   assign rtag = rvld_ff ? rtag_raw_ff : '0;

   assign entry_live = (rst == THR_QUEUED) && (rpl == q_ff) &&
                       (rtag == ent_ff[ENTW-1 -: TAG_W]);

   always_comb begin
      grp_sel = 0;
      for (int g = 1; g < NUM_GROUPS; g++) begin
         if (32'(e_idx) >= g * ENGINES_PER_GROUP) grp_sel = g;
      end
   end
   assign sq = QW'(NUM_ENGINES + grp_sel);

   always_comb begin
      dp_status.cmd         = cmd_ff;
      dp_status.engine_ok   = engine_ok;
      dp_status.pend_none   = (pk_ff[e_idx] == SLOT_NONE);
      dp_status.cur_thread  = (ck_ff[e_idx] == SLOT_THREAD);
      dp_status.fifo_empty  = (fill_ff[q_ff] == '0);
      dp_status.entry_live  = entry_live;
      dp_status.local_mode  = lmode_ff;
      dp_status.rec_running = (rst == THR_RUNNING);
      dp_status.out_free    = out_free;
   end

   always_comb begin
      logic             do_push;
      logic [ECW-1:0]   push_pin;
      logic [TAG_W-1:0] tag_new;
      logic [LTW-1:0]   lt_new;
      logic [CW-1:0]    best;
      logic             found;

      cmd_in   = cmd_ff;
      tid_in   = tid_ff;
      aff_in   = aff_ff;
      eng_in   = eng_ff;
      q_in     = q_ff;
      qnone_in = qnone_ff;
      lmode_in = lmode_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      lt_in    = lt_ff;
      sht_in   = sht_ff;
      pk_in    = pk_ff;
      pt_in    = pt_ff;
      ck_in    = ck_ff;
      ct_in    = ct_ff;
      res_status_in  = res_status_ff;
      res_chosen_in  = res_chosen_ff;
      res_idle_in    = res_idle_ff;
      res_resched_in = res_resched_ff;
      res_nvalid_in  = res_nvalid_ff;
      res_neng_in    = res_neng_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      trd_en   = 1'b0;
      trd_addr = tid_idx;
      twr_en   = 1'b0;
      twr_st   = rst;
      twr_pl   = rpl;
      twr_pin  = rpin;
      twr_tag  = rtag;
      srd_en   = 1'b0;
      srd_addr = SAW'(32'(q_ff) * QUEUE_DEPTH + 32'(head_ff[q_ff]));
      sw_en    = 1'b0;
      sw_addr  = SAW'(32'(q_ff) * QUEUE_DEPTH + 32'(tail_ff[q_ff]));
      tag_new  = rtag + 1'b1;
      sw_data  = {tag_new, trd_addr_ff};
      do_push  = 1'b0;
      push_pin = rpin;
      lt_new   = lt_ff[e_idx];
      best     = '0;
      found    = 1'b0;

      unique case (step)
         ST_IDLE: begin
            cmd_in = cmd_type'(req_cmd);
            tid_in = req_thread_id;
            aff_in = req_has_affinity;
            eng_in = req_engine_id;
         end
         ST_START: begin
            res_status_in  = RSP_OK;
            res_chosen_in  = '0;
            res_idle_in    = 1'b0;
            res_resched_in = 1'b0;
            res_nvalid_in  = 1'b0;
            res_neng_in    = '0;
            trd_en   = 1'b1;
            trd_addr = (cmd_ff == CMD_SWITCH) ? ct_ff[e_idx] : tid_idx;
            qnone_in = 1'b1;
            if (aff_ff) begin
               if (engine_ok) begin
                  q_in     = e_q;
                  qnone_in = 1'b0;
               end
            end else begin
               for (int g = 0; g < NUM_GROUPS; g++) begin
                  if (grp_engines(g, eiu_ff) != '0 &&
                      (!found || cnt_ff[NUM_ENGINES + g] < best)) begin
                     found = 1'b1;
                     best  = cnt_ff[NUM_ENGINES + g];
                     q_in  = QW'(NUM_ENGINES + g);
                  end
               end
               qnone_in = !found;
            end
            if (cmd_ff != CMD_ENQUEUE) begin
               priority if (!engine_ok) res_status_in = RSP_NO_QUEUE;
               else if (cmd_ff == CMD_SWITCH && pk_ff[e_idx] == SLOT_NONE)
                  res_status_in = RSP_BAD_STATE;
               else res_status_in = RSP_OK;
            end
         end
         ST_ENQ_CHECK: begin
            priority if (!tid_ok || rst != THR_READY) res_status_in = RSP_BAD_STATE;
            else if (qnone_ff || q_full) res_status_in = RSP_NO_QUEUE;
            else begin
               do_push  = 1'b1;
               push_pin = aff_ff ? ECW'(e_idx) + 1'b1 : '0;
            end
         end
         ST_RES_REFILL: begin
            if (sht_ff[e_idx] == '0) begin
               sht_in[e_idx] = cnt_ff[sq];
               lt_new = LTW'(cnt_ff[e_q] * grp_engines(grp_sel, eiu_ff));
               lt_in[e_idx] = lt_new;
            end
            lmode_in = (lt_new != '0);
            q_in     = (lt_new != '0) ? e_q : sq;
         end
         ST_POP_HEAD: begin
            if (fill_ff[q_ff] == '0) begin
               if (lmode_ff) begin
                  lmode_in = 1'b0;
                  q_in     = sq;
               end else begin
                  pk_in[e_idx] = SLOT_IDLE;
                  res_idle_in  = 1'b1;
               end
            end else begin
               srd_en = 1'b1;
               head_in[q_ff] = (32'(head_ff[q_ff]) + 1 == QUEUE_DEPTH) ? '0 :
                               head_ff[q_ff] + 1'b1;
               fill_in[q_ff] = fill_ff[q_ff] - 1'b1;
            end
         end
         ST_POP_ENTRY: begin
            trd_en   = 1'b1;
            trd_addr = ent_ff[TW-1:0];
         end
         ST_POP_CHECK: begin
            if (entry_live) begin
               if (cnt_ff[q_ff] != '0) cnt_in[q_ff] = cnt_ff[q_ff] - 1'b1;
               if (lmode_ff) lt_in[e_idx] = lt_ff[e_idx] - 1'b1;
               else if (sht_ff[e_idx] != '0) sht_in[e_idx] = sht_ff[e_idx] - 1'b1;
               twr_en = 1'b1;
               twr_st = THR_RUNNING;
               twr_pl = e_q;
               pk_in[e_idx] = SLOT_THREAD;
               pt_in[e_idx] = trd_addr_ff;
               res_chosen_in = TID_W'(trd_addr_ff);
            end
         end
         ST_SW_CUR: begin
            q_in = (rpin != '0) ? e_q : sq;
         end
         ST_SW_PUSH: begin
            if (q_full) begin
               twr_en = 1'b1;
               twr_st = THR_READY;
               res_status_in = RSP_NO_QUEUE;
            end else begin
               do_push  = 1'b1;
               push_pin = rpin;
            end
         end
         ST_SW_INSTALL: begin
            ck_in[e_idx] = pk_ff[e_idx];
            ct_in[e_idx] = pt_ff[e_idx];
            pk_in[e_idx] = SLOT_NONE;
            if (pk_ff[e_idx] == SLOT_THREAD) res_chosen_in = TID_W'(pt_ff[e_idx]);
            else res_idle_in = 1'b1;
         end
         ST_DEQ_CHECK: begin
            priority if (!tid_ok || (rst != THR_RUNNING && rst != THR_QUEUED)) begin
               res_status_in = RSP_BAD_STATE;
            end else if (rst == THR_RUNNING) begin
               twr_en = 1'b1;
               twr_st = THR_READY;
               if (rpl == e_q) begin
                  priority if (ck_ff[e_idx] == SLOT_THREAD && ct_ff[e_idx] == tid_idx)
                     res_resched_in = 1'b1;
                  else if (pk_ff[e_idx] == SLOT_THREAD && pt_ff[e_idx] == tid_idx)
                     pk_in[e_idx] = SLOT_NONE;
                  else res_resched_in = 1'b0;
               end else begin
                  res_nvalid_in = 1'b1;
                  res_neng_in   = ENG_W'(rpl);
               end
            end else begin
               twr_en = 1'b1;
               twr_st = THR_READY;
               if (32'(rpl) < NQ && cnt_ff[rpl] != '0) cnt_in[rpl] = cnt_ff[rpl] - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase

      if (do_push) begin
         sw_en   = 1'b1;
         tail_in[q_ff] = (32'(tail_ff[q_ff]) + 1 == QUEUE_DEPTH) ? '0 :
                         tail_ff[q_ff] + 1'b1;
         fill_in[q_ff] = fill_ff[q_ff] + 1'b1;
         cnt_in[q_ff]  = cnt_ff[q_ff] + 1'b1;
         twr_en  = 1'b1;
         twr_st  = THR_QUEUED;
         twr_pl  = q_ff;
         twr_pin = push_pin;
         twr_tag = tag_new;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff       <= ECW'(1);
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         fill_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         lt_ff        <= '{default: '0};
         sht_ff       <= '{default: '0};
         pk_ff        <= '{default: SLOT_NONE};
         ck_ff        <= '{default: SLOT_IDLE};
         tvld_ff      <= '{default: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            priority if (csr_wdata == '0) eiu_ff <= ECW'(1);
            else if (32'(csr_wdata) > NUM_ENGINES) eiu_ff <= ECW'(NUM_ENGINES);
            else eiu_ff <= ECW'(csr_wdata);
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         lt_ff        <= lt_in;
         sht_ff       <= sht_in;
         pk_ff        <= pk_in;
         ck_ff        <= ck_in;
         rsp_valid_ff <= rsp_valid_in;
         if (twr_en) tvld_ff[trd_addr_ff] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      tid_ff   <= tid_in;
      aff_ff   <= aff_in;
      eng_ff   <= eng_in;
      q_ff     <= q_in;
      qnone_ff <= qnone_in;
      lmode_ff <= lmode_in;
      pt_ff    <= pt_in;
      ct_ff    <= ct_in;
      res_status_ff  <= res_status_in;
      res_chosen_ff  <= res_chosen_in;
      res_idle_ff    <= res_idle_in;
      res_resched_ff <= res_resched_in;
      res_nvalid_ff  <= res_nvalid_in;
      res_neng_ff    <= res_neng_in;
      if (step == ST_DONE && out_free) begin
         rsp_status_ff  <= res_status_ff;
         rsp_chosen_ff  <= res_chosen_ff;
         rsp_idle_ff    <= res_idle_ff;
         rsp_resched_ff <= res_resched_ff;
         rsp_nvalid_ff  <= res_nvalid_ff;
         rsp_neng_ff    <= res_neng_ff;
      end
   end

   // thread table memory
   always_ff @(posedge clock) begin
      if (twr_en) begin
         st_mem[trd_addr_ff]  <= twr_st;
         pl_mem[trd_addr_ff]  <= twr_pl;
         pin_mem[trd_addr_ff] <= twr_pin;
         tag_mem[trd_addr_ff] <= twr_tag;
      end
      if (trd_en) begin
         trd_addr_ff <= trd_addr;
         rvld_ff     <= tvld_ff[trd_addr];
         rst_raw_ff  <= st_mem[trd_addr];
         rpl_raw_ff  <= pl_mem[trd_addr];
         rpin_raw_ff <= pin_mem[trd_addr];
         rtag_raw_ff <= tag_mem[trd_addr];
      end
   end

   // fifo storage memory
   always_ff @(posedge clock) begin
      if (sw_en) sto_mem[sw_addr] <= sw_data;
      if (srd_en) ent_ff <= sto_mem[srd_addr];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_chosen_thread     = rsp_chosen_ff;
   assign rsp_chose_idle        = rsp_idle_ff;
   assign rsp_reschedule_needed = rsp_resched_ff;
   assign rsp_notify_valid      = rsp_nvalid_ff;
   assign rsp_notify_engine     = rsp_neng_ff;

endmodule

/* hw/rtl/ticketed_run_queue_dispatcher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticketed_run_queue_dispatcher_unit
// Thread dispatcher with per-engine local FIFOs and per-cluster shared
// FIFOs, ticket based balancing between them.
// ----------------------------------------------------------------------------
// One command is processed at a time. Any command but enqueue on an engine
// not in use, and a switch with no pending thread, go from START straight to
// DONE. Enqueue passes through ENQ_CHECK and dequeue through DEQ_CHECK. Switch
// passes through SW_INSTALL, and before it through SW_CUR when the current
// slot holds a thread and then SW_PUSH when that thread is requeued.
// Reschedule passes RES_REFILL, then POP_HEAD, POP_ENTRY and POP_CHECK per FIFO
// entry read, stale entries included, plus a POP_HEAD visit for each FIFO found
// empty; each entry costs a FIFO memory read followed by a thread table read.
// The next transaction is taken once the response is in the output register,
// so a stalled response holds it off. No clearing pass is needed after reset.
module ticketed_run_queue_dispatcher_unit #(
   parameter int MAX_THREADS       = 64,
   parameter int NUM_ENGINES       = 8,
   parameter int ENGINES_PER_GROUP = 4,
   parameter int QUEUE_DEPTH       = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [trqd_pkg::CMD_W-1:0] req_cmd,
   input  logic [trqd_pkg::TID_W-1:0] req_thread_id,
   input  logic                       req_has_affinity,
   input  logic [trqd_pkg::ENG_W-1:0] req_engine_id,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [trqd_pkg::RSP_W-1:0] rsp_status,
   output logic [trqd_pkg::TID_W-1:0] rsp_chosen_thread,
   output logic                       rsp_chose_idle,
   output logic                       rsp_reschedule_needed,
   output logic                       rsp_notify_valid,
   output logic [trqd_pkg::ENG_W-1:0] rsp_notify_engine,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [trqd_pkg::CSR_W-1:0] csr_wdata
);
   import trqd_pkg::*;

   step_type      step;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   trqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .step      (step)
   );

   trqd_datapath #(
      .MAX_THREADS       (MAX_THREADS),
      .NUM_ENGINES       (NUM_ENGINES),
      .ENGINES_PER_GROUP (ENGINES_PER_GROUP),
      .QUEUE_DEPTH       (QUEUE_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .step                  (step),
      .dp_status             (dp_status),
      .req_cmd               (req_cmd),
      .req_thread_id         (req_thread_id),
      .req_has_affinity      (req_has_affinity),
      .req_engine_id         (req_engine_id),
      .csr_valid             (csr_valid && csr_ready),
      .csr_wdata             (csr_wdata),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_chosen_thread     (rsp_chosen_thread),
      .rsp_chose_idle        (rsp_chose_idle),
      .rsp_reschedule_needed (rsp_reschedule_needed),
      .rsp_notify_valid      (rsp_notify_valid),
      .rsp_notify_engine     (rsp_notify_engine)
   );

endmodule

/* dv/tb_ticketed_run_queue_dispatcher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ticketed_run_queue_dispatcher_unit
// Self-checking bench for the run queue dispatcher. A clocked driver sends
// commands from a queue and predicts each response on acceptance with its own
// scheduler state. A monitor compares every response field by field. The run
// steps through several engine counts and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_ticketed_run_queue_dispatcher_unit;

   localparam int NTHR      = 64;
   localparam int NENG      = 8;
   localparam int PER_GRP   = 4;
   localparam int NGRP      = 2;
   localparam int NQ        = NENG + NGRP;
   localparam int QDEPTH    = 64;
   localparam int SLOT_NONE_MARK = -1;
   localparam int SLOT_IDLE_MARK = -2;
   localparam int DRAIN_CYCLES   = 400;
   localparam int CYCLE_LIMIT    = 3000000;

   typedef struct {
      trqd_pkg::cmd_type cmd;
      logic [5:0]        tid;
      logic              aff;
      logic [2:0]        eng;
   } cmd_item_t;

   typedef struct {
      logic [1:0] status;
      logic [5:0] chosen;
      logic       idle;
      logic       resched;
      logic       nvalid;
      logic [2:0] neng;
   } dispatch_rsp_t;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic [1:0] req_cmd = 0;
   logic [5:0] req_thread_id = 0;
   logic       req_has_affinity = 0;
   logic [2:0] req_engine_id = 0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_chosen_thread;
   logic       rsp_chose_idle;
   logic       rsp_reschedule_needed;
   logic       rsp_notify_valid;
   logic [2:0] rsp_notify_engine;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [3:0] csr_wdata = 0;

   cmd_item_t     cmd_q[$];
   dispatch_rsp_t dispatch_expect_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit long_hold_req = 0;
   int cycles = 0;

   // scheduler shadow state
   int         engines;
   logic [1:0] thr_stat[NTHR];
   int         thr_place[NTHR];
   int         thr_pin[NTHR];
   logic [3:0] thr_tag[NTHR];
   logic [9:0] q_mem[NQ][QDEPTH];
   int q_head[NQ], q_tail[NQ], q_live[NQ], q_fill[NQ];
   int loc_tk[NENG], shr_tk[NENG], pend_slot[NENG], cur_slot[NENG];

   ticketed_run_queue_dispatcher_unit dut (.*);

   always #5 clock = ~clock;

   function automatic int grp_engines(int g);
      int left;
      if (engines <= g * PER_GRP) return 0;
      left = engines - g * PER_GRP;
      return left < PER_GRP ? left : PER_GRP;
   endfunction

   function automatic bit run_queue_push(int q, int t);
      if (q_fill[q] >= QDEPTH) return 0;
      thr_tag[t] = thr_tag[t] + 4'd1;
      q_mem[q][q_tail[q]] = {thr_tag[t], t[5:0]};
      q_tail[q] = (q_tail[q] + 1) % QDEPTH;
      q_fill[q]++;
      q_live[q]++;
      thr_stat[t] = trqd_pkg::THR_QUEUED;
      thr_place[t] = q;
      return 1;
   endfunction

   function automatic bit run_queue_pop(int q, output int t);
      logic [9:0] ent;
      int id;
      t = 0;
      while (q_fill[q] > 0) begin
         ent = q_mem[q][q_head[q]];
         id = ent[5:0];
         q_head[q] = (q_head[q] + 1) % QDEPTH;
         q_fill[q]--;
         if (thr_stat[id] == trqd_pkg::THR_QUEUED && thr_place[id] == q &&
             thr_tag[id] == ent[9:6]) begin
            if (q_live[q] > 0) q_live[q]--;
            t = id;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic void dispatch_predict(cmd_item_t it);
      dispatch_rsp_t r;
      int t, e, q, best, g, sq, pick, cur, p;
      bit got;
      r = '{default: 0};
      t = it.tid;
      e = it.eng;
      if (it.cmd == trqd_pkg::CMD_ENQUEUE) begin
         if (thr_stat[t] != trqd_pkg::THR_READY) begin
            r.status = trqd_pkg::RSP_BAD_STATE;
         end else begin
            q = -1;
            if (it.aff) begin
               if (e < engines) q = e;
            end else begin
               best = -1;
               for (g = 0; g < NGRP; g++)
                  if (grp_engines(g) != 0 && (best < 0 || q_live[NENG + g] < best)) begin
                     best = q_live[NENG + g];
                     q = NENG + g;
                  end
            end
            if (q < 0 || !run_queue_push(q, t)) r.status = trqd_pkg::RSP_NO_QUEUE;
            else thr_pin[t] = it.aff ? e + 1 : 0;
         end
      end else if (e >= engines) begin
         r.status = trqd_pkg::RSP_NO_QUEUE;
      end else if (it.cmd == trqd_pkg::CMD_RESCHEDULE) begin
         g = e / PER_GRP;
         sq = NENG + g;
         got = 0;
         if (shr_tk[e] == 0) begin
            shr_tk[e] = q_live[sq];
            loc_tk[e] = q_live[e] * grp_engines(g);
         end
         if (loc_tk[e] > 0) begin
            got = run_queue_pop(e, pick);
            if (got) loc_tk[e]--;
         end
         if (!got) begin
            got = run_queue_pop(sq, pick);
            if (got && shr_tk[e] > 0) shr_tk[e]--;
         end
         if (got) begin
            thr_stat[pick] = trqd_pkg::THR_RUNNING;
            thr_place[pick] = e;
            pend_slot[e] = pick;
            r.chosen = pick;
         end else begin
            pend_slot[e] = SLOT_IDLE_MARK;
            r.idle = 1;
         end
      end else if (it.cmd == trqd_pkg::CMD_SWITCH) begin
         cur = cur_slot[e];
         if (pend_slot[e] == SLOT_NONE_MARK) begin
            r.status = trqd_pkg::RSP_BAD_STATE;
         end else begin
            if (cur >= 0 && thr_stat[cur] == trqd_pkg::THR_RUNNING) begin
               q = thr_pin[cur] != 0 ? e : NENG + e / PER_GRP;
               if (!run_queue_push(q, cur)) begin
                  thr_stat[cur] = trqd_pkg::THR_READY;
                  r.status = trqd_pkg::RSP_NO_QUEUE;
               end
            end
            cur_slot[e] = pend_slot[e];
            pend_slot[e] = SLOT_NONE_MARK;
            if (cur_slot[e] >= 0) r.chosen = cur_slot[e];
            else r.idle = 1;
         end
      end else begin
         if (thr_stat[t] == trqd_pkg::THR_RUNNING) begin
            p = thr_place[t];
            thr_stat[t] = trqd_pkg::THR_READY;
            if (p == e) begin
               if (cur_slot[e] == t) r.resched = 1;
               else if (pend_slot[e] == t) pend_slot[e] = SLOT_NONE_MARK;
            end else begin
               r.nvalid = 1;
               r.neng = p[2:0];
            end
         end else if (thr_stat[t] == trqd_pkg::THR_QUEUED) begin
            q = thr_place[t];
            thr_stat[t] = trqd_pkg::THR_READY;
            if (q_live[q] > 0) q_live[q]--;
         end else begin
            r.status = trqd_pkg::RSP_BAD_STATE;
         end
      end
      dispatch_expect_q.push_back(r);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) dispatch_predict('{trqd_pkg::cmd_type'(req_cmd), req_thread_id,
                                           req_has_affinity, req_engine_id});
         if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1;
            req_cmd <= cmd_q[0].cmd;
            req_thread_id <= cmd_q[0].tid;
            req_has_affinity <= cmd_q[0].aff;
            req_engine_id <= cmd_q[0].eng;
            void'(cmd_q.pop_front());
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (long_hold_req) begin
         long_hold_req = 0;
         hold_left <= 600;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < stall_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      dispatch_rsp_t x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dispatch_expect_q.size() == 0) begin
            $error("unexpected transaction on response channel");
            errors++;
         end else begin
            x = dispatch_expect_q.pop_front();
            if (rsp_status !== x.status) begin
               $error("status: expected %0d, got %0d", x.status, rsp_status);
               errors++;
            end
            if (rsp_chosen_thread !== x.chosen) begin
               $error("chosen_thread: expected %0d, got %0d", x.chosen, rsp_chosen_thread);
               errors++;
            end
            if (rsp_chose_idle !== x.idle) begin
               $error("chose_idle: expected %0d, got %0d", x.idle, rsp_chose_idle);
               errors++;
            end
            if (rsp_reschedule_needed !== x.resched) begin
               $error("reschedule_needed: expected %0d, got %0d", x.resched,
                      rsp_reschedule_needed);
               errors++;
            end
            if (rsp_notify_valid !== x.nvalid) begin
               $error("notify_valid: expected %0d, got %0d", x.nvalid, rsp_notify_valid);
               errors++;
            end
            if (rsp_notify_engine !== x.neng) begin
               $error("notify_engine: expected %0d, got %0d", x.neng, rsp_notify_engine);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_ticketed_run_queue_dispatcher_unit: done, errors");
         $finish;
      end
   end

   task automatic write_engine_count(logic [3:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      engines = v == 0 ? 1 : (v > NENG ? NENG : v);
   endtask

   task automatic add_cmd(trqd_pkg::cmd_type c, int t, bit a, int e);
      cmd_q.push_back('{c, t[5:0], a, e[2:0]});
   endtask

   task automatic add_random(int n);
      int k, r, e;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         e = $urandom_range(0, 99) < 85 ? $urandom_range(0, engines - 1) : $urandom_range(0, 7);
         if (r < 32) begin
            add_cmd(trqd_pkg::CMD_ENQUEUE, $urandom_range(0, 63), $urandom_range(0, 1), e);
         end else if (r < 60) begin
            add_cmd(trqd_pkg::CMD_RESCHEDULE, $urandom_range(0, 63), $urandom_range(0, 1), e);
            if ($urandom_range(0, 99) < 65)
               add_cmd(trqd_pkg::CMD_SWITCH, $urandom_range(0, 63), $urandom_range(0, 1), e);
         end else if (r < 78) begin
            add_cmd(trqd_pkg::CMD_SWITCH, $urandom_range(0, 63), $urandom_range(0, 1), e);
         end else begin
            add_cmd(trqd_pkg::CMD_DEQUEUE, $urandom_range(0, 63), $urandom_range(0, 1), e);
         end
      end
   endtask

   task automatic run_phase(int idle_pct, int stl_pct);
      send_idle_pct = idle_pct;
      stall_pct = stl_pct;
      while (cmd_q.size() > 0 || req_valid) @(posedge clock);
      while (dispatch_expect_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int i;
      engines = 1;
      for (i = 0; i < NTHR; i++) begin
         thr_stat[i] = trqd_pkg::THR_READY;
         thr_place[i] = 0;
         thr_pin[i] = 0;
         thr_tag[i] = 0;
      end
      for (i = 0; i < NQ; i++) begin
         q_head[i] = 0; q_tail[i] = 0; q_live[i] = 0; q_fill[i] = 0;
      end
      for (i = 0; i < NENG; i++) begin
         loc_tk[i] = 0; shr_tk[i] = 0;
         pend_slot[i] = SLOT_NONE_MARK;
         cur_slot[i] = SLOT_IDLE_MARK;
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: every command and the special cases
      write_engine_count(8);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 1, 1, 0);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 2, 0, 0);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 63, 0, 7);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 0, 1, 7);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 2, 0, 0);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_DEQUEUE, 2, 0, 0);
      add_cmd(trqd_pkg::CMD_DEQUEUE, 63, 0, 0);
      add_cmd(trqd_pkg::CMD_DEQUEUE, 63, 0, 0);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 7);
      add_cmd(trqd_pkg::CMD_DEQUEUE, 0, 0, 7);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 7);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 5, 0, 4);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 4);
      add_cmd(trqd_pkg::CMD_DEQUEUE, 5, 0, 1);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 6);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 6);
      run_phase(0, 0);

      // one engine: full shared queue of stale entries, tag wrap, unused engines
      write_engine_count(0);
      for (i = 0; i < 64; i++) begin
         add_cmd(trqd_pkg::CMD_ENQUEUE, 9, 0, 0);
         add_cmd(trqd_pkg::CMD_DEQUEUE, 9, 0, 0);
      end
      add_cmd(trqd_pkg::CMD_ENQUEUE, 10, 0, 0);
      add_cmd(trqd_pkg::CMD_ENQUEUE, 11, 1, 3);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 5);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 5);
      add_cmd(trqd_pkg::CMD_DEQUEUE, 10, 0, 5);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_RESCHEDULE, 0, 0, 0);
      add_cmd(trqd_pkg::CMD_SWITCH, 0, 0, 0);
      run_phase(0, 0);

      write_engine_count(15);
      add_random(140);
      run_phase(0, 0);

      write_engine_count(3);
      long_hold_req = 1;
      add_random(130);
      run_phase(45, 0);

      write_engine_count(5);
      add_random(130);
      run_phase(0, 45);

      write_engine_count(1);
      add_random(120);
      run_phase(38, 38);

      write_engine_count(8);
      add_random(130);
      run_phase(0, 0);

      write_engine_count($urandom_range(1, 8));
      add_random(105);
      run_phase(38, 38);

      if (errors == 0)
         $display("tb_ticketed_run_queue_dispatcher_unit: done, clean");
      else
         $display("tb_ticketed_run_queue_dispatcher_unit: done, errors");
      $finish;
   end

endmodule
